### rtl/core/dds_pkg.sv
// Shared types, constants and the sine table for the DDS tone generator.
package dds_pkg;

  localparam int CLOCK_HZ_DEF = 16000000;
  localparam int FREQ_W       = 16;
  localparam int INC_SHIFT    = 24;
  localparam int PHASE_W      = 16;
  localparam int IDX_W        = 6;
  localparam int VOL_W        = 8;
  localparam int SAMPLE_W     = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam logic [VOL_W-1:0] VOL_RESET = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_FREQ   = 2'd1,
    CFG_VOLUME = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               busy;
    logic [PHASE_W-1:0] inc;
  } div_status_t;

  function automatic logic [SAMPLE_W-1:0] sine_rom(input logic [IDX_W-1:0] idx);
    logic [SAMPLE_W-1:0] v;
    case (idx)
      6'd0:  v = 8'd127;  6'd1:  v = 8'd139;  6'd2:  v = 8'd151;  6'd3:  v = 8'd163;
      6'd4:  v = 8'd175;  6'd5:  v = 8'd186;  6'd6:  v = 8'd197;  6'd7:  v = 8'd207;
      6'd8:  v = 8'd216;  6'd9:  v = 8'd225;  6'd10: v = 8'd232;  6'd11: v = 8'd239;
      6'd12: v = 8'd244;  6'd13: v = 8'd248;  6'd14: v = 8'd251;  6'd15: v = 8'd253;
      6'd16: v = 8'd254;  6'd17: v = 8'd253;  6'd18: v = 8'd251;  6'd19: v = 8'd248;
      6'd20: v = 8'd244;  6'd21: v = 8'd239;  6'd22: v = 8'd232;  6'd23: v = 8'd225;
      6'd24: v = 8'd216;  6'd25: v = 8'd207;  6'd26: v = 8'd197;  6'd27: v = 8'd186;
      6'd28: v = 8'd175;  6'd29: v = 8'd163;  6'd30: v = 8'd151;  6'd31: v = 8'd139;
      6'd32: v = 8'd127;  6'd33: v = 8'd114;  6'd34: v = 8'd102;  6'd35: v = 8'd90;
      6'd36: v = 8'd78;   6'd37: v = 8'd67;   6'd38: v = 8'd56;   6'd39: v = 8'd46;
      6'd40: v = 8'd37;   6'd41: v = 8'd28;   6'd42: v = 8'd21;   6'd43: v = 8'd14;
      6'd44: v = 8'd9;    6'd45: v = 8'd5;    6'd46: v = 8'd2;    6'd47: v = 8'd1;
      6'd48: v = 8'd1;    6'd49: v = 8'd1;    6'd50: v = 8'd2;    6'd51: v = 8'd5;
      6'd52: v = 8'd9;    6'd53: v = 8'd14;   6'd54: v = 8'd21;   6'd55: v = 8'd28;
      6'd56: v = 8'd37;   6'd57: v = 8'd46;   6'd58: v = 8'd56;   6'd59: v = 8'd67;
      6'd60: v = 8'd78;   6'd61: v = 8'd90;   6'd62: v = 8'd102;  6'd63: v = 8'd114;
      default: v = 8'd127;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/dds_inc_div.sv
// Phase increment (freq << 24) / CLOCK_HZ: reciprocal multiply, then one correction step.
module dds_inc_div #(
  parameter int CLOCK_HZ = dds_pkg::CLOCK_HZ_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dds_pkg::FREQ_W-1:0]  freq,
  output dds_pkg::div_status_t        status
);
  import dds_pkg::*;

  // estimate = (freq * floor(2^40 / CLOCK_HZ)) >> 16 is the quotient or one below it
  localparam int RECIP_SHIFT = FREQ_W;
  localparam longint unsigned RECIP =
    (64'd1 << (INC_SHIFT + RECIP_SHIFT)) / 64'(CLOCK_HZ);
  localparam int RECIP_W = $clog2(RECIP + 64'd1);
  localparam int PROD_W  = FREQ_W + RECIP_W;
  // remainder stays below 2 * CLOCK_HZ, so its low REM_W bits are enough
  localparam int REM_W   = $clog2(CLOCK_HZ + 1) + 1;
  localparam logic [REM_W-1:0]  DIVISOR = REM_W'(CLOCK_HZ);
  localparam logic [PROD_W-1:0] RECIP_P = PROD_W'(RECIP);

  logic [1:0]         cnt_r;
  logic [PHASE_W-1:0] inc_r;
  logic [RECIP_W-1:0] est_r;
  logic [REM_W-1:0]   num_lo_r;
  logic [REM_W-1:0]   back_r;

  logic [PROD_W-1:0]  prod;
  logic [REM_W-1:0]   rem;
  logic               fix;

  always_comb begin
    prod = PROD_W'(freq) * RECIP_P;
    rem  = num_lo_r - back_r;
    fix  = (rem >= DIVISOR);
  end

  // start: estimate; next cycle: estimate * CLOCK_HZ; last cycle: correct by one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      inc_r <= '0;
    end else if (start) begin
      cnt_r <= 2'd2;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 2'd1;
      if (cnt_r == 2'd1) begin
        inc_r <= PHASE_W'(est_r) + PHASE_W'(fix);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      est_r    <= prod[PROD_W-1 -: RECIP_W];
      num_lo_r <= REM_W'({freq, INC_SHIFT'(0)});
    end
    if (cnt_r == 2'd2) begin
      back_r <= REM_W'(est_r) * DIVISOR;
    end
  end

  assign status.busy = (cnt_r != '0);
  assign status.inc  = inc_r;

endmodule

### rtl/core/dds_scale.sv
// Sine table lookup and volume scaling, floor(volume * v / 255).
module dds_scale (
  input  logic [dds_pkg::IDX_W-1:0]    idx,
  input  logic [dds_pkg::VOL_W-1:0]    volume,
  output logic [dds_pkg::SAMPLE_W-1:0] sample
);
  import dds_pkg::*;

  logic [SAMPLE_W-1:0]        rom_v;
  logic [VOL_W+SAMPLE_W-1:0]  prod;
  logic [VOL_W+SAMPLE_W-1:0]  sum;

  // exact divide by 255 for products below 2^16: (p + (p >> 8) + 1) >> 8
  always_comb begin
    rom_v  = sine_rom(idx);
    prod   = (VOL_W + SAMPLE_W)'(volume) * (VOL_W + SAMPLE_W)'(rom_v);
    sum    = prod + (prod >> 8) + (VOL_W + SAMPLE_W)'(1);
    sample = sum[VOL_W+SAMPLE_W-1:8];
  end

endmodule

### rtl/core/dds_sine_tone_generator.sv
// s1_idx_r, then out_data_r register an accepted tick's sample word; 1 word/cycle when not stalled.
// A tone_freq write starts a 3-step increment calculation; in_stall stays high while it runs.
// The phase adder and table/scale stage otherwise give one word a cycle while out_stall is low.
// Synchronous reset clears phase, pipeline valids, enable, frequency; volume resets to 255.
// Ticks taken while disabled, or with tick low, yield no word and keep the phase.
module dds_sine_tone_generator #(
  parameter int CLOCK_HZ = dds_pkg::CLOCK_HZ_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_tick,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dds_pkg::SAMPLE_W-1:0]     out_pwm_compare,
  input  logic                             cfg_wr_en,
  input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dds_pkg::*;

  logic                enable_r;
  logic [VOL_W-1:0]    volume_r;
  logic [PHASE_W-1:0]  phase_r;
  logic                s1_vld_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;

  div_status_t         div_st;
  logic                freq_wr;
  logic                in_accept;
  logic                take;
  logic                s1_adv;
  logic [PHASE_W-1:0]  phase_nxt;
  logic [SAMPLE_W-1:0] sample;

  assign freq_wr   = cfg_wr_en && (cfg_idx_t'(cfg_index) == CFG_FREQ);
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = div_st.busy || (s1_vld_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;
  assign take      = in_accept && in_tick && enable_r;
  assign phase_nxt = phase_r + div_st.inc;

  dds_inc_div #(
    .CLOCK_HZ(CLOCK_HZ)
  ) u_inc_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (freq_wr),
    .freq  (cfg_data[FREQ_W-1:0]),
    .status(div_st)
  );

  dds_scale u_scale (
    .idx   (s1_idx_r),
    .volume(volume_r),
    .sample(sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      volume_r <= VOL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_VOLUME: volume_r <= cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // advance phase only on an enabled tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      s1_vld_r <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_idx_r <= phase_nxt[PHASE_W-1 -: IDX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) begin
      out_data_r <= sample;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pwm_compare = out_data_r;

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> in_stall)
    else $error("input taken while increment division runs");

  a_freq_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    freq_wr |=> div_st.busy)
    else $error("frequency write did not start the divider");

  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> s1_vld_r)
    else $error("enabled tick lost before the scale stage");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(phase_r))
    else $error("phase moved without an enabled tick");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> (s1_vld_r && $stable(s1_idx_r)))
    else $error("stalled stage word dropped or changed");
`endif

endmodule

### tb/sv/dds_sine_tone_generator_test.sv
// Self-checking testbench for the DDS sine tone generator: directed and random tick streams.
module dds_sine_tone_generator_test;
  import dds_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_SAMPLES = 1000;
  localparam int SETTLE_CYCLES = 4;

  // quarter-wave symmetric sine levels, 1..254 around 127
  localparam logic [SAMPLE_W-1:0] SINE_LEVELS [64] = '{
    8'd127, 8'd139, 8'd151, 8'd163, 8'd175, 8'd186, 8'd197, 8'd207,
    8'd216, 8'd225, 8'd232, 8'd239, 8'd244, 8'd248, 8'd251, 8'd253,
    8'd254, 8'd253, 8'd251, 8'd248, 8'd244, 8'd239, 8'd232, 8'd225,
    8'd216, 8'd207, 8'd197, 8'd186, 8'd175, 8'd163, 8'd151, 8'd139,
    8'd127, 8'd114, 8'd102, 8'd90,  8'd78,  8'd67,  8'd56,  8'd46,
    8'd37,  8'd28,  8'd21,  8'd14,  8'd9,   8'd5,   8'd2,   8'd1,
    8'd1,   8'd1,   8'd2,   8'd5,   8'd9,   8'd14,  8'd21,  8'd28,
    8'd37,  8'd46,  8'd56,  8'd67,  8'd78,  8'd90,  8'd102, 8'd114
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_tick = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_pwm_compare;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // tone generator shadow state
  logic tone_on = 1'b0;
  logic [FREQ_W-1:0] tone_hz = '0;
  logic [VOL_W-1:0] gain = VOL_RESET;
  logic [PHASE_W-1:0] phase = '0;

  logic [SAMPLE_W-1:0] sample_q [$];
  int mismatches = 0;
  int samples_sent = 0;
  int idle_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  dds_sine_tone_generator uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_tick(in_tick),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pwm_compare(out_pwm_compare),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the phase by one step and return the scaled sample.
  function automatic logic [SAMPLE_W-1:0] advance_tone();
    logic [63:0] scaled;
    logic [PHASE_W-1:0] step;
    logic [15:0] product;
    scaled = {48'd0, tone_hz} << INC_SHIFT;
    step = PHASE_W'(scaled / 64'(CLOCK_HZ_DEF));
    phase = phase + step;
    product = 16'(gain) * 16'(SINE_LEVELS[phase[PHASE_W-1 -: IDX_W]]);
    return SAMPLE_W'(product / 16'd255);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_ENABLE: tone_on = data[0];
      CFG_FREQ:   tone_hz = data;
      CFG_VOLUME: gain = data[VOL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_tick(input bit tick);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= tick;
    do @(posedge clk); while (in_stall);
    if (tick && tone_on) begin
      sample_q.push_back(advance_tone());
      samples_sent++;
    end
  endtask

  // Hold the sender until every expected sample has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sample_q.size() != 0);
  endtask

  // Drain, then let the pipeline settle with the input idle.
  task automatic wait_idle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_idle_after_reset();
    repeat (2) send_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_default_volume();
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_FREQ, 16'd1000);
    repeat (3) send_tick(1'b1);
  endtask

  task automatic test_tick_low();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_freq_edges();
    write_reg(CFG_FREQ, 16'd0);
    repeat (2) send_tick(1'b1);
    wait_idle();
    // exactly one full turn per tick: the increment wraps to zero
    write_reg(CFG_FREQ, 16'd62500);
    repeat (2) send_tick(1'b1);
    wait_idle();
    write_reg(CFG_FREQ, 16'hFFFF);
    repeat (3) send_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_volume_edges();
    write_reg(CFG_VOLUME, 16'd0);
    repeat (2) send_tick(1'b1);
    wait_idle();
    write_reg(CFG_VOLUME, 16'd1);
    repeat (2) send_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_wide_writes();
    write_reg(CFG_VOLUME, 16'hFF80);
    write_reg(CFG_ENABLE, 16'hFFFE);
    send_tick(1'b1);
    wait_idle();
    write_reg(CFG_ENABLE, 16'hFFFF);
    repeat (2) send_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_spare_index();
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(CFG_SPARE, 16'h0000);
    repeat (2) send_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_random_phases();
    int goal;
    int count;
    bit on;
    logic [FREQ_W-1:0] hz;
    logic [CFG_DATA_W-1:0] vol;
    goal = samples_sent + RANDOM_SAMPLES;
    while (samples_sent < goal) begin
      wait_idle();
      if ($urandom_range(0, 3) == 0) tx_steady = !tx_steady;
      on = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 3))
        0: vol = {8'($urandom_range(0, 255)), 8'(($urandom_range(0, 1) == 0) ? 0 : 255)};
        1: vol = {8'($urandom), 8'($urandom_range(0, 3) == 0 ? 1 : 254)};
        default: vol = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: hz = 16'($urandom);
        1: begin
          case ($urandom_range(0, 5))
            0: hz = 16'd0;
            1: hz = 16'd1;
            2: hz = 16'd62499;
            3: hz = 16'd62500;
            4: hz = 16'd62501;
            default: hz = 16'hFFFF;
          endcase
        end
        2: hz = 16'($urandom_range(62000, 65535));
        default: hz = 16'($urandom_range(0, 4000));
      endcase
      write_reg(CFG_VOLUME, vol);
      write_reg(CFG_ENABLE, {15'($urandom), on});
      // frequency last: its increment division stalls the input meanwhile
      write_reg(CFG_FREQ, hz);
      count = on ? $urandom_range(5, 60) : $urandom_range(2, 8);
      for (int i = 0; i < count; i++) begin
        send_tick($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 199) == 0) wait_drain();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_after_reset();
    test_default_volume();
    test_tick_low();
    test_freq_edges();
    test_volume_edges();
    test_wide_writes();
    test_spare_index();
    test_random_phases();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && sample_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before taking each word.
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 47) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (sample_q.size() == 0) begin
        $error("pwm_compare: expected none, actual %0d", out_pwm_compare);
        mismatches++;
      end else begin
        want = sample_q.pop_front();
        if (out_pwm_compare !== want) begin
          $error("pwm_compare: expected %0d, actual %0d", want, out_pwm_compare);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### sim.f
rtl/core/dds_pkg.sv
rtl/core/dds_inc_div.sv
rtl/core/dds_scale.sv
rtl/core/dds_sine_tone_generator.sv
tb/sv/dds_sine_tone_generator_test.sv
